/* rtl/core/dq_pkg.sv */
// Package for the double-ended queue: request/response payload structs,
// request and status codes, cell link and cell control types.
// No dependencies.
package dq_pkg;

   localparam int unsigned DATA_W = 32;

   typedef enum logic [1:0] {
      REQ_PUSH_FRONT = 2'd0,
      REQ_PUSH_BACK  = 2'd1,
      REQ_POP_FRONT  = 2'd2,
      REQ_POP_BACK   = 2'd3
   } dq_op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } dq_status_type;

   typedef struct packed {
      logic [1:0]               req_type;
      logic signed [DATA_W-1:0] push_value;
   } dq_req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] pop_value;
      logic                     now_empty;
   } dq_rsp_type;

   // What one cell shows its neighbors.
   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] value;
   } dq_link_type;

   // Broadcast to every cell for one accepted request.
   typedef struct packed {
      logic shift_r;    // push front: move everything one cell toward the back
      logic shift_l;    // pop front: move everything one cell toward the front
      logic put_back;   // push back: first free cell takes the value
      logic drop_back;  // pop back: last occupied cell empties
   } dq_ctrl_type;

endpackage

/* rtl/core/dq_cell.sv */
// One storage cell of the deque chain: a value and an occupied bit.
// Depends on dq_pkg for the link and control structs.
module dq_cell
   import dq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  dq_ctrl_type       ctrl,
   input  logic [DATA_W-1:0] push_value,
   input  dq_link_type       left_link,
   input  dq_link_type       right_link,
   output dq_link_type       self_link,
   output logic [DATA_W-1:0] tail_value
);

   logic              valid_ff, valid_in;
   logic [DATA_W-1:0] value_ff, value_in;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctrl.shift_r) begin
         valid_in = left_link.valid;
         value_in = left_link.value;
      end else if (ctrl.shift_l) begin
         valid_in = right_link.valid;
         value_in = right_link.value;
      end else if (ctrl.put_back) begin
         if (!valid_ff && left_link.valid) begin
            valid_in = 1'b1;
            value_in = push_value;
         end
      end else if (ctrl.drop_back) begin
         if (valid_ff && !right_link.valid) begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign self_link.valid = valid_ff;
   assign self_link.value = value_ff;

   // Only the last occupied cell shows its value to the back-pop select.
   assign tail_value = (valid_ff && !right_link.valid) ? value_ff : '0;

endmodule

/* rtl/core/double_ended_queue.sv */
// Double-ended queue of signed 32-bit values, DEPTH entries, built as a
// row of cells with the front at cell 0; depends on dq_pkg and dq_cell.
//
// Request channel (req_valid/req_stall/req_data): one request per transfer,
// push front, push back, pop front or pop back. Result channel
// (rsp_valid/rsp_stall/rsp_data): exactly one result per request, in order,
// with status (done, empty on pop, full on push), the popped value (zero
// unless a pop succeeded) and whether the deque is empty afterwards.
// The result of a request taken at one edge is in the result register after
// it. Throughput is one request per cycle while req_stall is low; every cell
// updates in that same cycle, shifting to its neighbor for front operations
// or acting alone for back operations, and the back value comes from an OR
// over the cells that the last occupied cell drives.
// While the receiver stalls with a result waiting, req_stall is high and no
// request is taken; the result holds.
// Reset (synchronous, active high) empties the deque and drops any pending
// result. A full push or empty pop leaves the contents unchanged.
module double_ended_queue
   import dq_pkg::*;
#(
   parameter int unsigned DEPTH = 16
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  dq_req_type req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output dq_rsp_type rsp_data
);

   dq_link_type              links [DEPTH];
   logic [DATA_W-1:0]        tails [DEPTH];
   logic [DEPTH-1:0]         occ;
   logic [DATA_W-1:0]        back_value;
   logic                     accept;
   logic                     is_empty, is_full, is_push;
   dq_ctrl_type              ctrl;
   logic                     rsp_valid_ff, rsp_valid_in;
   dq_rsp_type               rsp_ff, rsp_in;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign is_empty = !occ[0];
   assign is_full  = occ[DEPTH-1];
   assign is_push  = (req_data.req_type == REQ_PUSH_FRONT) ||
                     (req_data.req_type == REQ_PUSH_BACK);

   always_comb begin
      ctrl = '0;
      if (accept) begin
         case (req_data.req_type)
            REQ_PUSH_FRONT: ctrl.shift_r   = !is_full;
            REQ_PUSH_BACK:  ctrl.put_back  = !is_full;
            REQ_POP_FRONT:  ctrl.shift_l   = !is_empty;
            REQ_POP_BACK:   ctrl.drop_back = !is_empty;
            default:        ctrl = '0;
         endcase
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      dq_link_type left_link, right_link;

      if (i == 0) begin : g_first
         assign left_link.valid = 1'b1;
         assign left_link.value = req_data.push_value;
      end else begin : g_mid_l
         assign left_link = links[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_link = '0;
      end else begin : g_mid_r
         assign right_link = links[i+1];
      end

      dq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .push_value (req_data.push_value),
         .left_link  (left_link),
         .right_link (right_link),
         .self_link  (links[i]),
         .tail_value (tails[i])
      );

      assign occ[i] = links[i].valid;
   end

   // At most one cell drives a nonzero tail value.
   always_comb begin
      back_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         back_value = back_value | tails[i];
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (accept) begin
         rsp_in.pop_value = '0;
         if (is_push) begin
            rsp_in.status    = is_full ? ST_FULL : ST_DONE;
            rsp_in.now_empty = 1'b0;
         end else begin
            rsp_in.status    = is_empty ? ST_EMPTY : ST_DONE;
            rsp_in.now_empty = !occ[1];
            if (!is_empty) begin
               rsp_in.pop_value = (req_data.req_type == REQ_POP_FRONT) ?
                                  links[0].value : back_value;
            end
         end
      end
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   logic [DEPTH:0] occ_ext;
   assign occ_ext = {1'b0, occ};

   a_occ_prefix: assert property (@(posedge clock) disable iff (reset)
      (occ_ext & (occ_ext + 1'b1)) == '0)
      else $error("occupied cells are not a contiguous run from the front");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && is_push && is_full) |=> $stable(occ))
      else $error("refused push changed the contents");

   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_valid && ($past(is_push) ? !rsp_data.now_empty : 1'b1)))
      else $error("accepted request left no result");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_DONE) |-> (rsp_data.pop_value == '0))
      else $error("refused request carries a nonzero value");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      (accept && !is_push) |=> (rsp_data.now_empty == !occ[0]))
      else $error("empty flag disagrees with cell occupancy");
`endif

endmodule
